/* rtl/core/ansi_text_terminal_cursor_engine_macros.svh */
// Assertion macros used by the back end of the terminal cursor engine.
`ifndef ANSI_TEXT_TERMINAL_CURSOR_ENGINE_MACROS_SVH
`define ANSI_TEXT_TERMINAL_CURSOR_ENGINE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ATC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atc assertion failed");
`define ATC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atc assertion failed");
`else
`define ATC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ATC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/atc_pkg.sv */
`default_nettype none
package atc_pkg;

   localparam int TAB_STOP    = 8;
   localparam int MAX_RESULTS = 9;
   localparam int RUN_LIMIT   = MAX_RESULTS - 1;
   localparam int RUN_W       = $clog2(RUN_LIMIT + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ATTR_RESET   = 8'h0F;
   localparam logic [7:0] ATTR_BG_MASK = 8'hF0;

   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_ESC       = 8'h1B;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;
   localparam logic [7:0] CH_SEMI      = 8'h3B;
   localparam logic [7:0] CH_FINAL_H   = 8'h48;
   localparam logic [7:0] CH_FINAL_J   = 8'h4A;
   localparam logic [7:0] CH_CSI       = 8'h5B;
   localparam logic [7:0] CH_FINAL_F   = 8'h66;
   localparam logic [7:0] CH_FINAL_M   = 8'h6D;

   localparam logic [7:0] ARG_MAX         = 8'd255;
   localparam logic [7:0] ED_TO_END       = 8'd0;
   localparam logic [7:0] ED_ALL          = 8'd2;
   localparam logic [7:0] SGR_RESET       = 8'd0;
   localparam logic [7:0] SGR_FG_LOW      = 8'd30;
   localparam logic [7:0] SGR_FG_HIGH     = 8'd37;
   localparam logic [7:0] SGR_BRIGHT_LOW  = 8'd90;
   localparam logic [7:0] SGR_BRIGHT_HIGH = 8'd97;

   localparam logic [2:0] CMD_CURSOR = 3'd0;
   localparam logic [2:0] CMD_DRAW   = 3'd1;
   localparam logic [2:0] CMD_ERASE  = 3'd2;
   localparam logic [2:0] CMD_CLEAR  = 3'd3;
   localparam logic [2:0] CMD_SCROLL = 3'd4;

   localparam logic REG_SCREEN_COLUMNS = 1'b0;
   localparam logic REG_SCREEN_ROWS    = 1'b1;

   localparam logic [7:0] COLUMNS_RESET = 8'd80;
   localparam logic [7:0] ROWS_RESET    = 8'd25;

   localparam logic [3:0] FG_MAP [15] = '{4'd0, 4'd4, 4'd2, 4'd6, 4'd1, 4'd5, 4'd3, 4'd7,
                                          4'd8, 4'd12, 4'd10, 4'd14, 4'd9, 4'd13, 4'd11};

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_SEEN,
      ESC_CSI
   } esc_state_type;

   typedef enum logic {
      BACK_IDLE,
      BACK_EMIT
   } back_state_type;

   typedef enum logic [2:0] {
      OP_GLYPH,
      OP_TAB,
      OP_NEWLINE,
      OP_RETURN,
      OP_BACKSPACE,
      OP_CLEAR,
      OP_HOME,
      OP_REPORT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] glyph;
      logic [7:0] color;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef struct packed {
      logic [7:0] columns;
      logic [7:0] rows;
   } screen_cfg_type;

   function automatic logic [3:0] fg_from_offset(logic [7:0] offset);
      return FG_MAP[{1'b0, offset[2:0]}];
   endfunction

endpackage
`default_nettype wire

/* rtl/core/atc_front.sv */
`default_nettype none
module atc_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [7:0]               req_char_code,
   input  wire atc_pkg::queue_status_type queue_status,
   output logic                          push,
   output atc_pkg::queue_entry_type      push_entry
);

   atc_pkg::esc_state_type esc_ff, esc_in;
   logic [7:0] first_arg_ff, first_arg_in;
   logic [7:0] second_arg_ff, second_arg_in;
   logic       arg_select_ff, arg_select_in;
   logic [7:0] attr_ff, attr_in;

   logic        accept;
   logic        is_digit;
   logic        is_semi;
   logic [7:0]  acc;
   logic [11:0] product;
   logic [7:0]  acc_sat;
   logic [7:0]  attr_m;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;
   assign is_digit  = (req_char_code >= atc_pkg::CH_DIGIT_0) &&
                      (req_char_code <= atc_pkg::CH_DIGIT_9);
   assign is_semi   = (req_char_code == atc_pkg::CH_SEMI);
   assign acc       = arg_select_ff ? second_arg_ff : first_arg_ff;
   assign product   = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                      + {8'h00, req_char_code[3:0]};
   assign acc_sat   = (product > {4'h0, atc_pkg::ARG_MAX}) ? atc_pkg::ARG_MAX : product[7:0];

   always_comb begin
      attr_m = attr_ff;
      if (first_arg_ff == atc_pkg::SGR_RESET) begin
         attr_m = atc_pkg::ATTR_RESET;
      end else if ((first_arg_ff >= atc_pkg::SGR_FG_LOW) &&
                   (first_arg_ff <= atc_pkg::SGR_FG_HIGH)) begin
         attr_m = (attr_ff & atc_pkg::ATTR_BG_MASK) |
                  {4'h0, atc_pkg::fg_from_offset(first_arg_ff - atc_pkg::SGR_FG_LOW)};
      end else if ((first_arg_ff >= atc_pkg::SGR_BRIGHT_LOW) &&
                   (first_arg_ff <= atc_pkg::SGR_BRIGHT_HIGH)) begin
         attr_m = (attr_ff & atc_pkg::ATTR_BG_MASK) |
                  {4'h0, atc_pkg::fg_from_offset(first_arg_ff - atc_pkg::SGR_BRIGHT_LOW)};
      end
      if ((second_arg_ff >= atc_pkg::SGR_FG_LOW) &&
          (second_arg_ff <= atc_pkg::SGR_FG_HIGH)) begin
         attr_m = (attr_m & atc_pkg::ATTR_BG_MASK) |
                  {4'h0, atc_pkg::fg_from_offset(second_arg_ff - atc_pkg::SGR_FG_LOW)};
      end
   end

   always_comb begin
      esc_in = esc_ff;
      if (accept) begin
         unique case (esc_ff)
            atc_pkg::ESC_IDLE: begin
               if (req_char_code == atc_pkg::CH_ESC) begin
                  esc_in = atc_pkg::ESC_SEEN;
               end
            end
            atc_pkg::ESC_SEEN: begin
               esc_in = (req_char_code == atc_pkg::CH_CSI) ? atc_pkg::ESC_CSI
                                                          : atc_pkg::ESC_IDLE;
            end
            atc_pkg::ESC_CSI: begin
               if (!is_digit && !is_semi) begin
                  esc_in = atc_pkg::ESC_IDLE;
               end
            end
            default: esc_in = atc_pkg::ESC_IDLE;
         endcase
      end
   end

   always_comb begin
      first_arg_in     = first_arg_ff;
      second_arg_in    = second_arg_ff;
      arg_select_in    = arg_select_ff;
      attr_in          = attr_ff;
      push             = 1'b0;
      push_entry.op    = atc_pkg::OP_REPORT;
      push_entry.glyph = req_char_code;
      if (accept) begin
         unique case (esc_ff)
            atc_pkg::ESC_IDLE: begin
               if (req_char_code == atc_pkg::CH_ESC) begin
                  first_arg_in  = '0;
                  second_arg_in = '0;
                  arg_select_in = 1'b0;
               end else begin
                  push = 1'b1;
                  unique case (req_char_code)
                     atc_pkg::CH_NEWLINE:   push_entry.op = atc_pkg::OP_NEWLINE;
                     atc_pkg::CH_RETURN:    push_entry.op = atc_pkg::OP_RETURN;
                     atc_pkg::CH_TAB:       push_entry.op = atc_pkg::OP_TAB;
                     atc_pkg::CH_BACKSPACE: push_entry.op = atc_pkg::OP_BACKSPACE;
                     default:               push_entry.op = atc_pkg::OP_GLYPH;
                  endcase
               end
            end
            atc_pkg::ESC_CSI: begin
               if (is_digit) begin
                  if (arg_select_ff) begin
                     second_arg_in = acc_sat;
                  end else begin
                     first_arg_in = acc_sat;
                  end
               end else if (is_semi) begin
                  arg_select_in = 1'b1;
               end else begin
                  push = 1'b1;
                  if ((req_char_code == atc_pkg::CH_FINAL_J) &&
                      ((first_arg_ff == atc_pkg::ED_TO_END) ||
                       (first_arg_ff == atc_pkg::ED_ALL))) begin
                     push_entry.op = atc_pkg::OP_CLEAR;
                  end else if ((req_char_code == atc_pkg::CH_FINAL_H) ||
                               (req_char_code == atc_pkg::CH_FINAL_F)) begin
                     push_entry.op = atc_pkg::OP_HOME;
                  end else begin
                     push_entry.op = atc_pkg::OP_REPORT;
                     if (req_char_code == atc_pkg::CH_FINAL_M) begin
                        attr_in = attr_m;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      push_entry.color = attr_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff        <= atc_pkg::ESC_IDLE;
         first_arg_ff  <= '0;
         second_arg_ff <= '0;
         arg_select_ff <= 1'b0;
         attr_ff       <= atc_pkg::ATTR_RESET;
      end else begin
         esc_ff        <= esc_in;
         first_arg_ff  <= first_arg_in;
         second_arg_ff <= second_arg_in;
         arg_select_ff <= arg_select_in;
         attr_ff       <= attr_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/atc_queue.sv */
`default_nettype none
module atc_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire atc_pkg::queue_entry_type  push_entry,
   input  wire logic                      pop,
   output atc_pkg::queue_entry_type       head,
   output atc_pkg::queue_status_type      status
);

   atc_pkg::queue_entry_type entries_ff [atc_pkg::QUEUE_DEPTH];
   logic [atc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [atc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [atc_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   function automatic logic [atc_pkg::QUEUE_PTR_W-1:0] ptr_next(
      logic [atc_pkg::QUEUE_PTR_W-1:0] ptr);
      return (ptr == atc_pkg::QUEUE_PTR_W'(atc_pkg::QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   assign head             = entries_ff[rd_ptr_ff];
   assign status.full      = (count_ff == atc_pkg::QUEUE_CNT_W'(atc_pkg::QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/atc_back.sv */
`default_nettype none
`include "ansi_text_terminal_cursor_engine_macros.svh"
module atc_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire atc_pkg::screen_cfg_type   cfg,
   input  wire atc_pkg::queue_status_type queue_status,
   input  wire atc_pkg::queue_entry_type  head,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [2:0]                     rsp_command,
   output logic [7:0]                     rsp_cell_x,
   output logic [7:0]                     rsp_cell_y,
   output logic [7:0]                     rsp_glyph,
   output logic [7:0]                     rsp_color,
   output logic [7:0]                     rsp_cursor_col,
   output logic [7:0]                     rsp_cursor_row,
   output logic                           rsp_last
);

   atc_pkg::back_state_type state_ff, state_in;

   logic [7:0]               col_ff, row_ff;
   logic [7:0]               run_x_ff, run_y_ff;
   logic [atc_pkg::RUN_W-1:0] run_left_ff;
   logic [7:0]               glyph_ff, color_ff;
   logic                     tail_valid_ff;
   logic [2:0]               tail_cmd_ff;
   logic [7:0]               tail_x_ff, tail_y_ff, tail_glyph_ff;

   logic                     rsp_valid_ff;
   logic [2:0]               rsp_command_ff;
   logic [7:0]               rsp_cell_x_ff, rsp_cell_y_ff, rsp_glyph_ff, rsp_color_ff;
   logic [7:0]               rsp_cursor_col_ff, rsp_cursor_row_ff;
   logic                     rsp_last_ff;

   logic [7:0] cols_eff, rows_eff;
   logic [8:0] row_next9;
   logic       nl_scroll;
   logic [7:0] nl_row;
   logic [8:0] tab_phase, tab_room, line_room, room_min, run_len9, run_end;
   logic       wrap;

   logic [7:0]               plan_col, plan_row;
   logic [atc_pkg::RUN_W-1:0] plan_run;
   logic                     plan_tail_valid;
   logic [2:0]               plan_tail_cmd;
   logic [7:0]               plan_tail_x, plan_tail_y, plan_tail_glyph;
   logic [7:0]               plan_glyph;

   logic       out_free;
   logic       emit;
   logic       emit_run;
   logic       emit_last;
   logic [2:0] emit_cmd;
   logic [7:0] emit_x, emit_y, emit_glyph;

   assign cols_eff  = (cfg.columns == 8'd0) ? 8'd1 : cfg.columns;
   assign rows_eff  = (cfg.rows == 8'd0) ? 8'd1 : cfg.rows;
   assign row_next9 = {1'b0, row_ff} + 9'd1;
   assign nl_scroll = (row_next9 >= {1'b0, rows_eff});
   assign nl_row    = nl_scroll ? (rows_eff - 8'd1) : row_next9[7:0];
   assign tab_phase = {1'b0, col_ff % 8'(atc_pkg::TAB_STOP)};
   assign tab_room  = 9'(atc_pkg::TAB_STOP) - tab_phase;
   assign line_room = (col_ff < cols_eff) ? {1'b0, cols_eff - col_ff} : 9'd1;
   assign room_min  = (tab_room < line_room) ? tab_room : line_room;
   assign run_len9  = (head.op == atc_pkg::OP_TAB)
                      ? ((room_min < 9'(atc_pkg::RUN_LIMIT)) ? room_min
                                                              : 9'(atc_pkg::RUN_LIMIT))
                      : 9'd1;
   assign run_end   = {1'b0, col_ff} + run_len9;
   assign wrap      = (run_end >= {1'b0, cols_eff});

   always_comb begin
      plan_col        = col_ff;
      plan_row        = row_ff;
      plan_run        = '0;
      plan_tail_valid = 1'b1;
      plan_tail_cmd   = atc_pkg::CMD_CURSOR;
      plan_tail_x     = 8'd0;
      plan_tail_y     = 8'd0;
      plan_tail_glyph = 8'd0;
      plan_glyph      = (head.op == atc_pkg::OP_TAB) ? atc_pkg::CH_SPACE : head.glyph;
      unique case (head.op) inside
         atc_pkg::OP_GLYPH, atc_pkg::OP_TAB: begin
            plan_run      = atc_pkg::RUN_W'(run_len9);
            plan_tail_cmd = atc_pkg::CMD_SCROLL;
            if (wrap) begin
               plan_col        = 8'd0;
               plan_row        = nl_row;
               plan_tail_valid = nl_scroll;
            end else begin
               plan_col        = run_end[7:0];
               plan_tail_valid = 1'b0;
            end
         end
         atc_pkg::OP_NEWLINE: begin
            plan_col      = 8'd0;
            plan_row      = nl_row;
            plan_tail_cmd = nl_scroll ? atc_pkg::CMD_SCROLL : atc_pkg::CMD_CURSOR;
         end
         atc_pkg::OP_RETURN: begin
            plan_col = 8'd0;
         end
         atc_pkg::OP_BACKSPACE: begin
            if (col_ff != 8'd0) begin
               plan_col = col_ff - 8'd1;
            end else if (row_ff != 8'd0) begin
               plan_row = row_ff - 8'd1;
               plan_col = cols_eff - 8'd1;
            end
            plan_tail_cmd   = atc_pkg::CMD_ERASE;
            plan_tail_x     = plan_col;
            plan_tail_y     = plan_row;
            plan_tail_glyph = atc_pkg::CH_SPACE;
         end
         atc_pkg::OP_CLEAR: begin
            plan_col      = 8'd0;
            plan_row      = 8'd0;
            plan_tail_cmd = atc_pkg::CMD_CLEAR;
         end
         atc_pkg::OP_HOME: begin
            plan_col = 8'd0;
            plan_row = 8'd0;
         end
         default: begin
         end
      endcase
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_run  = (run_left_ff != '0);
   assign emit_last = emit_run ? ((run_left_ff == atc_pkg::RUN_W'(1)) && !tail_valid_ff)
                               : 1'b1;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         atc_pkg::BACK_IDLE: begin
            if (queue_status.not_empty) begin
               state_in = atc_pkg::BACK_EMIT;
            end
         end
         atc_pkg::BACK_EMIT: begin
            if (out_free && emit_last) begin
               state_in = atc_pkg::BACK_IDLE;
            end
         end
         default: state_in = atc_pkg::BACK_IDLE;
      endcase
   end

   always_comb begin
      pop  = 1'b0;
      emit = 1'b0;
      unique case (state_ff)
         atc_pkg::BACK_IDLE: pop  = queue_status.not_empty;
         atc_pkg::BACK_EMIT: emit = out_free;
         default: begin
         end
      endcase
      emit_cmd   = emit_run ? atc_pkg::CMD_DRAW : tail_cmd_ff;
      emit_x     = emit_run ? run_x_ff : tail_x_ff;
      emit_y     = emit_run ? run_y_ff : tail_y_ff;
      emit_glyph = emit_run ? glyph_ff : tail_glyph_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= atc_pkg::BACK_IDLE;
         col_ff        <= 8'd0;
         row_ff        <= 8'd0;
         run_left_ff   <= '0;
         tail_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (pop) begin
            col_ff        <= plan_col;
            row_ff        <= plan_row;
            run_left_ff   <= plan_run;
            tail_valid_ff <= plan_tail_valid;
         end else if (emit) begin
            if (emit_run) begin
               run_left_ff <= run_left_ff - 1'b1;
            end else begin
               tail_valid_ff <= 1'b0;
            end
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         run_x_ff      <= col_ff;
         run_y_ff      <= row_ff;
         glyph_ff      <= plan_glyph;
         color_ff      <= head.color;
         tail_cmd_ff   <= plan_tail_cmd;
         tail_x_ff     <= plan_tail_x;
         tail_y_ff     <= plan_tail_y;
         tail_glyph_ff <= plan_tail_glyph;
      end else if (emit && emit_run) begin
         run_x_ff <= run_x_ff + 8'd1;
      end
      if (emit) begin
         rsp_command_ff    <= emit_cmd;
         rsp_cell_x_ff     <= emit_x;
         rsp_cell_y_ff     <= emit_y;
         rsp_glyph_ff      <= emit_glyph;
         rsp_color_ff      <= color_ff;
         rsp_cursor_col_ff <= col_ff;
         rsp_cursor_row_ff <= row_ff;
         rsp_last_ff       <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command    = rsp_command_ff;
   assign rsp_cell_x     = rsp_cell_x_ff;
   assign rsp_cell_y     = rsp_cell_y_ff;
   assign rsp_glyph      = rsp_glyph_ff;
   assign rsp_color      = rsp_color_ff;
   assign rsp_cursor_col = rsp_cursor_col_ff;
   assign rsp_cursor_row = rsp_cursor_row_ff;
   assign rsp_last       = rsp_last_ff;

   `ATC_ASSERT_IMPLY(emit_has_work, clock, reset, state_ff == atc_pkg::BACK_EMIT, (run_left_ff != '0) || tail_valid_ff)
   `ATC_ASSERT_IMPLY(idle_has_no_work, clock, reset, state_ff == atc_pkg::BACK_IDLE, (run_left_ff == '0) && !tail_valid_ff)
   `ATC_ASSERT_IMPLY(run_bounded, clock, reset, 1'b1, run_left_ff <= atc_pkg::RUN_W'(atc_pkg::RUN_LIMIT))
   `ATC_ASSERT_NEXT(cursor_held_while_emitting, clock, reset, state_ff == atc_pkg::BACK_EMIT, $stable(col_ff) && $stable(row_ff))

endmodule
`default_nettype wire

/* rtl/core/ansi_text_terminal_cursor_engine.sv */
// A byte that yields results is written into the command queue, then popped into the back
// end, which registers its results onto the outputs and emits them all before its next pop.
// Escape bytes and up to two further bytes, held in the command queue, are taken at one per
// cycle meanwhile, while the queue is not full. A tab yields up to nine results, one per
// cycle while the result side does not stall. Reset puts the cursor at home, the attribute
// at 0x0F, the parser idle, the queue empty and the screen size at 80 columns by 25 rows.
`default_nettype none
module ansi_text_terminal_cursor_engine (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_char_code,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_command,
   output logic [7:0]       rsp_cell_x,
   output logic [7:0]       rsp_cell_y,
   output logic [7:0]       rsp_glyph,
   output logic [7:0]       rsp_color,
   output logic [7:0]       rsp_cursor_col,
   output logic [7:0]       rsp_cursor_row,
   output logic             rsp_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [7:0] screen_columns_ff, screen_rows_ff;
   logic       csr_write;

   atc_pkg::screen_cfg_type   cfg;
   atc_pkg::queue_status_type queue_status;
   atc_pkg::queue_entry_type  push_entry;
   atc_pkg::queue_entry_type  head;
   logic                      push;
   logic                      pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_columns_ff <= atc_pkg::COLUMNS_RESET;
         screen_rows_ff    <= atc_pkg::ROWS_RESET;
      end else if (csr_write) begin
         unique case (paddr[2])
            atc_pkg::REG_SCREEN_COLUMNS: screen_columns_ff <= pwdata[7:0];
            atc_pkg::REG_SCREEN_ROWS:    screen_rows_ff    <= pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         atc_pkg::REG_SCREEN_COLUMNS: prdata = {24'h000000, screen_columns_ff};
         atc_pkg::REG_SCREEN_ROWS:    prdata = {24'h000000, screen_rows_ff};
         default:                     prdata = 32'h00000000;
      endcase
   end

   assign cfg.columns = screen_columns_ff;
   assign cfg.rows    = screen_rows_ff;

   atc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .queue_status  (queue_status),
      .push          (push),
      .push_entry    (push_entry)
   );

   atc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (queue_status)
   );

   atc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .queue_status   (queue_status),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_command    (rsp_command),
      .rsp_cell_x     (rsp_cell_x),
      .rsp_cell_y     (rsp_cell_y),
      .rsp_glyph      (rsp_glyph),
      .rsp_color      (rsp_color),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_last       (rsp_last)
   );

endmodule
`default_nettype wire

/* tb/sv/ansi_text_terminal_cursor_engine_tb.sv */
`timescale 1ns / 1ps
module ansi_text_terminal_cursor_engine_tb;

   localparam int QUIET_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [2:0] command;
      logic [7:0] cell_x;
      logic [7:0] cell_y;
      logic [7:0] glyph;
      logic [7:0] color;
      logic [7:0] cursor_col;
      logic [7:0] cursor_row;
      logic       last;
   } display_cmd_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_code = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_command;
   logic [7:0]  rsp_cell_x;
   logic [7:0]  rsp_cell_y;
   logic [7:0]  rsp_glyph;
   logic [7:0]  rsp_color;
   logic [7:0]  rsp_cursor_col;
   logic [7:0]  rsp_cursor_row;
   logic        rsp_last;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = 3'd0;
   logic [31:0] pwdata = 32'd0;
   logic [31:0] prdata;
   logic        pready;

   ansi_text_terminal_cursor_engine uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_command(rsp_command),
      .rsp_cell_x(rsp_cell_x),
      .rsp_cell_y(rsp_cell_y),
      .rsp_glyph(rsp_glyph),
      .rsp_color(rsp_color),
      .rsp_cursor_col(rsp_cursor_col),
      .rsp_cursor_row(rsp_cursor_row),
      .rsp_last(rsp_last),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Terminal state as the block should hold it.
   int unsigned            screen_cols_cfg = atc_pkg::COLUMNS_RESET;
   int unsigned            screen_rows_cfg = atc_pkg::ROWS_RESET;
   int unsigned            cur_col = 0;
   int unsigned            cur_row = 0;
   logic [7:0]             cur_attr = atc_pkg::ATTR_RESET;
   atc_pkg::esc_state_type parse_state = atc_pkg::ESC_IDLE;
   int unsigned            arg_first = 0;
   int unsigned            arg_second = 0;
   logic                   arg_sel = 1'b0;
   display_cmd_type        staged [atc_pkg::MAX_RESULTS];
   int                     staged_n = 0;
   display_cmd_type        display_cmds_due [$];

   int                     mismatch_count = 0;
   int                     bytes_sent = 0;
   int                     burst_left = 0;
   int                     idle_cycles = 0;
   display_cmd_type        due_cmd;

   function automatic int unsigned clamp_size(int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic void stage_cmd(logic [2:0] cmd, int unsigned x, int unsigned y,
                                     logic [7:0] g);
      if (staged_n >= atc_pkg::MAX_RESULTS)
         return;
      staged[staged_n].command = cmd;
      staged[staged_n].cell_x  = 8'(x);
      staged[staged_n].cell_y  = 8'(y);
      staged[staged_n].glyph   = g;
      staged[staged_n].color   = cur_attr;
      staged_n++;
   endfunction

   function automatic bit advance_row();
      cur_col = 0;
      if (cur_row + 1 >= clamp_size(screen_rows_cfg)) begin
         cur_row = clamp_size(screen_rows_cfg) - 1;
         return 1'b1;
      end
      cur_row++;
      return 1'b0;
   endfunction

   function automatic void draw_glyph(logic [7:0] g);
      int unsigned x;
      int unsigned y;
      bit          scrolled;
      x = cur_col;
      y = cur_row;
      scrolled = 1'b0;
      cur_col++;
      if (cur_col >= clamp_size(screen_cols_cfg))
         scrolled = advance_row();
      stage_cmd(atc_pkg::CMD_DRAW, x, y, g);
      if (scrolled)
         stage_cmd(atc_pkg::CMD_SCROLL, 0, 0, 8'h00);
   endfunction

   function automatic void set_foreground(int unsigned idx);
      cur_attr = (cur_attr & atc_pkg::ATTR_BG_MASK) | {4'h0, atc_pkg::FG_MAP[idx % 8]};
   endfunction

   function automatic void publish_cmds();
      for (int k = 0; k < staged_n; k++) begin
         staged[k].cursor_col = 8'(cur_col);
         staged[k].cursor_row = 8'(cur_row);
         staged[k].last       = (k == staged_n - 1);
         display_cmds_due.push_back(staged[k]);
      end
   endfunction

   function automatic void interpret_byte(logic [7:0] c);
      int unsigned built;
      staged_n = 0;
      case (parse_state)
         atc_pkg::ESC_IDLE: begin
            if (c == atc_pkg::CH_ESC) begin
               parse_state = atc_pkg::ESC_SEEN;
               arg_first = 0;
               arg_second = 0;
               arg_sel = 1'b0;
               return;
            end
         end
         atc_pkg::ESC_SEEN: begin
            parse_state = (c == atc_pkg::CH_CSI) ? atc_pkg::ESC_CSI : atc_pkg::ESC_IDLE;
            return;
         end
         atc_pkg::ESC_CSI: begin
            if (c >= atc_pkg::CH_DIGIT_0 && c <= atc_pkg::CH_DIGIT_9) begin
               built = (arg_sel ? arg_second : arg_first) * 10 + (c - atc_pkg::CH_DIGIT_0);
               if (built > atc_pkg::ARG_MAX)
                  built = atc_pkg::ARG_MAX;
               if (arg_sel)
                  arg_second = built;
               else
                  arg_first = built;
               return;
            end
            if (c == atc_pkg::CH_SEMI) begin
               arg_sel = 1'b1;
               return;
            end
            parse_state = atc_pkg::ESC_IDLE;
            if (c == atc_pkg::CH_FINAL_J &&
                (arg_first == atc_pkg::ED_TO_END || arg_first == atc_pkg::ED_ALL)) begin
               cur_col = 0;
               cur_row = 0;
               stage_cmd(atc_pkg::CMD_CLEAR, 0, 0, 8'h00);
            end else begin
               if (c == atc_pkg::CH_FINAL_H || c == atc_pkg::CH_FINAL_F) begin
                  cur_col = 0;
                  cur_row = 0;
               end else if (c == atc_pkg::CH_FINAL_M) begin
                  if (arg_first == atc_pkg::SGR_RESET)
                     cur_attr = atc_pkg::ATTR_RESET;
                  else if (arg_first >= atc_pkg::SGR_FG_LOW &&
                           arg_first <= atc_pkg::SGR_FG_HIGH)
                     set_foreground(arg_first - atc_pkg::SGR_FG_LOW);
                  else if (arg_first >= atc_pkg::SGR_BRIGHT_LOW &&
                           arg_first <= atc_pkg::SGR_BRIGHT_HIGH)
                     set_foreground(arg_first - atc_pkg::SGR_BRIGHT_LOW);
                  if (arg_second >= atc_pkg::SGR_FG_LOW && arg_second <= atc_pkg::SGR_FG_HIGH)
                     set_foreground(arg_second - atc_pkg::SGR_FG_LOW);
               end
               stage_cmd(atc_pkg::CMD_CURSOR, 0, 0, 8'h00);
            end
            publish_cmds();
            return;
         end
         default: begin
            parse_state = atc_pkg::ESC_IDLE;
            return;
         end
      endcase

      if (c == atc_pkg::CH_NEWLINE) begin
         stage_cmd(advance_row() ? atc_pkg::CMD_SCROLL : atc_pkg::CMD_CURSOR, 0, 0, 8'h00);
      end else if (c == atc_pkg::CH_RETURN) begin
         cur_col = 0;
         stage_cmd(atc_pkg::CMD_CURSOR, 0, 0, 8'h00);
      end else if (c == atc_pkg::CH_TAB) begin
         do begin
            draw_glyph(atc_pkg::CH_SPACE);
         end while (cur_col != 0 && (cur_col % atc_pkg::TAB_STOP) != 0 &&
                    staged_n + 2 <= atc_pkg::MAX_RESULTS);
      end else if (c == atc_pkg::CH_BACKSPACE) begin
         if (cur_col > 0) begin
            cur_col--;
         end else if (cur_row > 0) begin
            cur_row--;
            cur_col = clamp_size(screen_cols_cfg) - 1;
         end
         stage_cmd(atc_pkg::CMD_ERASE, cur_col, cur_row, atc_pkg::CH_SPACE);
      end else begin
         draw_glyph(c);
      end
      publish_cmds();
   endfunction

   task automatic send_byte(input logic [7:0] c);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 4))
            @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_valid <= 1'b1;
      req_char_code <= c;
      do
         @(posedge clock);
      while (req_stall);
      interpret_byte(c);
      bytes_sent++;
      burst_left--;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic wait_until_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (display_cmds_due.size() != 0)
         @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_sel, 2'b00};
      pwdata <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      if (reg_sel == atc_pkg::REG_SCREEN_COLUMNS)
         screen_cols_cfg = value;
      else
         screen_rows_cfg = value;
   endtask

   task automatic csr_read(input logic reg_sel, input logic [7:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {reg_sel, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do
         @(posedge clock);
      while (!pready);
      if (prdata !== {24'h0, value}) begin
         $display("%0t: register %0d expected %0h actual %0h", $time, reg_sel, value, prdata);
         mismatch_count++;
      end
   endtask

   task automatic set_screen_size(input logic [7:0] cols, input logic [7:0] rows);
      wait_until_drained();
      csr_write(atc_pkg::REG_SCREEN_COLUMNS, cols);
      csr_write(atc_pkg::REG_SCREEN_ROWS, rows);
      csr_read(atc_pkg::REG_SCREEN_COLUMNS, cols);
      csr_read(atc_pkg::REG_SCREEN_ROWS, rows);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic send_escape_sequence();
      int nargs;
      int value;
      send_byte(atc_pkg::CH_ESC);
      if ($urandom_range(0, 9) == 0) begin
         send_byte(8'($urandom_range(0, 255)));
         return;
      end
      send_byte(atc_pkg::CH_CSI);
      nargs = $urandom_range(0, 3);
      for (int i = 0; i < nargs; i++) begin
         if (i > 0)
            send_byte(atc_pkg::CH_SEMI);
         case ($urandom_range(0, 4))
            0: value = $urandom_range(0, 1) * 2;
            1: value = atc_pkg::SGR_FG_LOW + $urandom_range(0, 7);
            2: value = atc_pkg::SGR_BRIGHT_LOW + $urandom_range(0, 7);
            3: value = $urandom_range(0, 999);
            default: value = -1;
         endcase
         if (value >= 0) begin
            if ($urandom_range(0, 7) == 0)
               send_byte(atc_pkg::CH_DIGIT_0);
            send_text($sformatf("%0d", value));
         end
      end
      case ($urandom_range(0, 5))
         0: send_byte(atc_pkg::CH_FINAL_J);
         1: send_byte(atc_pkg::CH_FINAL_H);
         2: send_byte(atc_pkg::CH_FINAL_F);
         3, 4: send_byte(atc_pkg::CH_FINAL_M);
         default: send_byte(8'($urandom_range(0, 255)));
      endcase
   endtask

   task automatic run_text(input int count);
      int start;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: send_escape_sequence();
            7, 8, 9, 10, 11, 12, 13: send_byte(8'($urandom_range(8'h20, 8'h7E)));
            14: send_byte(atc_pkg::CH_NEWLINE);
            15: send_byte(atc_pkg::CH_RETURN);
            16: send_byte(atc_pkg::CH_TAB);
            17: send_byte(atc_pkg::CH_BACKSPACE);
            default: send_byte(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   task automatic test_register_defaults();
      csr_read(atc_pkg::REG_SCREEN_COLUMNS, atc_pkg::COLUMNS_RESET);
      csr_read(atc_pkg::REG_SCREEN_ROWS, atc_pkg::ROWS_RESET);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic test_control_bytes();
      // Backspace at home erases the home cell; the last one wraps to the row above.
      send_byte(atc_pkg::CH_BACKSPACE);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(atc_pkg::CH_TAB);
      send_byte(atc_pkg::CH_BACKSPACE);
      send_byte(atc_pkg::CH_RETURN);
      send_byte(atc_pkg::CH_NEWLINE);
      send_byte(atc_pkg::CH_BACKSPACE);
   endtask

   task automatic test_escape_sequences();
      send_byte(atc_pkg::CH_ESC);
      send_byte(8'h71);
      send_byte(atc_pkg::CH_ESC);
      send_text("[2J");
      // A second separator keeps adding digits to the second argument.
      send_byte(atc_pkg::CH_ESC);
      send_text("[92;3;1m");
   endtask

   task automatic test_default_screen();
      run_text(60);
   endtask

   task automatic test_zero_size_screen();
      set_screen_size(8'd0, 8'd0);
      run_text(40);
   endtask

   task automatic test_single_cell_screen();
      set_screen_size(8'd1, 8'd1);
      run_text(40);
   endtask

   task automatic test_largest_screen();
      set_screen_size(8'd255, 8'd255);
      run_text(60);
   endtask

   task automatic test_shrunk_screen();
      set_screen_size(8'd9, 8'd4);
      run_text(50);
   endtask

   task automatic test_random_screens();
      for (int i = 0; i < 3; i++) begin
         set_screen_size(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         run_text(20);
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (display_cmds_due.size() == 0) begin
            $display("%0t: command expected none actual %0h", $time, rsp_command);
            mismatch_count++;
         end else begin
            due_cmd = display_cmds_due.pop_front();
            check_field("command", {5'h0, due_cmd.command}, {5'h0, rsp_command});
            check_field("cell_x", due_cmd.cell_x, rsp_cell_x);
            check_field("cell_y", due_cmd.cell_y, rsp_cell_y);
            check_field("glyph", due_cmd.glyph, rsp_glyph);
            check_field("color", due_cmd.color, rsp_color);
            check_field("cursor_col", due_cmd.cursor_col, rsp_cursor_col);
            check_field("cursor_row", due_cmd.cursor_row, rsp_cursor_row);
            check_field("last", {7'h0, due_cmd.last}, {7'h0, rsp_last});
         end
      end
   end

   int stall_mode = 0;
   int stall_left = 0;
   int stall_phase = 0;
   int stall_period = 4;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(20, 80);
         stall_period = $urandom_range(2, 9);
      end
      stall_left--;
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ((stall_phase % stall_period) < stall_period / 2);
      endcase
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_defaults();
      test_control_bytes();
      test_escape_sequences();
      test_default_screen();
      test_zero_size_screen();
      test_single_cell_screen();
      test_largest_screen();
      test_shrunk_screen();
      test_random_screens();
      wait_until_drained();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
